// ===== src/ipacl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix access list package
// Shared widths, codes, the rule record and the prefix compare helpers.
// ----------------------------------------------------------------------------
package ipacl_pkg;

  localparam int MAX_RULES_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int FAMILY_W = 2;
  localparam int ADDR_W   = 64;
  localparam int WB_W     = 4;
  localparam int MASK_W   = 8;
  localparam int MATCH_W  = 6;
  localparam int KEY_W    = 128;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_FILTER_ENABLE = 1'b0;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RSVD   = 2'd3;

  localparam logic [FAMILY_W-1:0] FAM_V4   = 2'd0;
  localparam logic [FAMILY_W-1:0] FAM_V6   = 2'd1;
  localparam logic [FAMILY_W-1:0] FAM_BAD  = 2'd2;
  localparam logic [FAMILY_W-1:0] FAM_RSVD = 2'd3;

  localparam logic [31:0] MAPPED_V4_TAG = 32'h0000_ffff;
  localparam logic [7:0]  BYTE_ONES     = 8'hff;
  localparam logic [4:0]  V4_BYTES      = 5'd4;
  localparam logic [4:0]  V6_BYTES      = 5'd16;

  typedef struct packed {
    logic              is_v6;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [WB_W-1:0]   whole_bytes;
    logic [MASK_W-1:0] partial_mask;
  } rule_t;

  // Address bytes left aligned, byte 0 in the top bits.
  function automatic logic [KEY_W-1:0] rule_key(input logic v6,
                                                input logic [ADDR_W-1:0] hi,
                                                input logic [ADDR_W-1:0] lo);
    logic [KEY_W-1:0] k;
    if (v6) begin
      k = {hi, lo};
    end else begin
      k = {lo[31:0], 96'd0};
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] prefix_mask(input logic v6,
                                                   input logic [WB_W-1:0] wb,
                                                   input logic [MASK_W-1:0] pm);
    logic [4:0]       len;
    logic [4:0]       wbs;
    logic [KEY_W-1:0] m;
    len = v6 ? V6_BYTES : V4_BYTES;
    wbs = ({1'b0, wb} > len) ? len : {1'b0, wb};
    m   = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < wbs) begin
        m[KEY_W-1-8*i -: 8] = BYTE_ONES;
      end else if (5'(i) == wbs && wbs < len) begin
        m[KEY_W-1-8*i -: 8] = pm;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/ipacl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix access list channels
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface ipacl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  family_code;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [3:0]  whole_bytes;
  logic [7:0]  partial_mask;

  modport source (output valid, action, family_code, addr_high, addr_low,
                  whole_bytes, partial_mask, input ready);
  modport sink (input valid, action, family_code, addr_high, addr_low,
                whole_bytes, partial_mask, output ready);
endinterface

interface ipacl_out_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [5:0] matched_rule;
  logic       table_overflow;

  modport source (output valid, allowed, matched_rule, table_overflow,
                  input ready);
  modport sink (input valid, allowed, matched_rule, table_overflow,
                output ready);
endinterface

// ===== src/ip_prefix_access_list_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix access list matcher
// Clear, append and check transactions against a table of prefix rules.
// Clear, append and checks that need no table walk: result registered in the
// cycle after acceptance. A walking check reads one rule per cycle through the
// single memory read port and ends at the first hit or after the last rule.
// One transaction at a time. Synchronous active-low reset empties the table
// and disables filtering; rule memory contents are not cleared.
// ----------------------------------------------------------------------------
module ip_prefix_access_list_match #(
  parameter int MAX_RULES = ipacl_pkg::MAX_RULES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ipacl_in_if.sink                         in_chan,
  ipacl_out_if.source                      out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ipacl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ipacl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ipacl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import ipacl_pkg::*;

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic          state_r, state_nxt;
  logic          filter_en_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic          q_v6_r, q_v6_nxt;
  logic [KEY_W-1:0] q_key_r, q_key_nxt;

  logic         out_vld_r, out_vld_nxt;
  logic         out_allowed_r, out_allowed_nxt;
  logic [MATCH_W-1:0] out_matched_r, out_matched_nxt;
  logic         out_ovf_r, out_ovf_nxt;

  logic         in_acc, cfg_wr, fam_ok, is_mapped, eff_v6, table_full, hit, last;
  logic         mem_we;
  rule_t        wr_rule, rd_rule;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_FILTER_ENABLE) ?
                      {{(CFG_DATA_W-1){1'b0}}, filter_en_r} : '0;

  assign in_chan.ready = (state_r == S_IDLE) && (!out_vld_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign out_chan.valid          = out_vld_r;
  assign out_chan.allowed        = out_allowed_r;
  assign out_chan.matched_rule   = out_matched_r;
  assign out_chan.table_overflow = out_ovf_r;

  assign fam_ok     = (in_chan.family_code == FAM_V4) || (in_chan.family_code == FAM_V6);
  assign is_mapped  = (in_chan.family_code == FAM_V6) && (in_chan.addr_high == '0) &&
                      (in_chan.addr_low[63:32] == MAPPED_V4_TAG);
  assign eff_v6     = (in_chan.family_code == FAM_V6) && !is_mapped;
  assign table_full = (count_r == CW'(MAX_RULES));

  assign wr_rule.is_v6        = (in_chan.family_code == FAM_V6);
  assign wr_rule.addr_high    = in_chan.addr_high;
  assign wr_rule.addr_low     = in_chan.addr_low;
  assign wr_rule.whole_bytes  = in_chan.whole_bytes;
  assign wr_rule.partial_mask = in_chan.partial_mask;

  assign mem_we = in_acc && (in_chan.action == ACT_APPEND) && fam_ok && !table_full;

  ipacl_rule_mem #(
    .DEPTH (MAX_RULES),
    .AW    (AW)
  ) u_rule_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_rule),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_rule)
  );

  // Shared compare unit: one stored rule against the query key per cycle.
  assign hit = cmp_vld_r && (rd_rule.is_v6 == q_v6_r) &&
               (((rule_key(q_v6_r, rd_rule.addr_high, rd_rule.addr_low) ^ q_key_r) &
                 prefix_mask(q_v6_r, rd_rule.whole_bytes, rd_rule.partial_mask)) == '0);
  assign last = cmp_vld_r && ((CW'(cmp_idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_vld_nxt     = 1'b0;
    q_v6_nxt        = q_v6_r;
    q_key_nxt       = q_key_r;
    out_vld_nxt     = out_vld_r && !out_chan.ready;
    out_allowed_nxt = out_allowed_r;
    out_matched_nxt = out_matched_r;
    out_ovf_nxt     = out_ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_allowed_nxt = 1'b0;
          out_matched_nxt = '0;
          out_ovf_nxt     = 1'b0;
          case (in_chan.action)
            ACT_CLEAR: begin
              count_nxt   = '0;
              out_vld_nxt = 1'b1;
            end
            ACT_APPEND: begin
              out_vld_nxt = 1'b1;
              if (fam_ok) begin
                if (table_full) begin
                  out_ovf_nxt = 1'b1;
                end else begin
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            ACT_CHECK: begin
              if (!filter_en_r) begin
                out_allowed_nxt = 1'b1;
                out_vld_nxt     = 1'b1;
              end else if (!fam_ok || count_r == '0) begin
                out_vld_nxt = 1'b1;
              end else begin
                q_v6_nxt   = eff_v6;
                q_key_nxt  = rule_key(eff_v6, in_chan.addr_high, in_chan.addr_low);
                rd_idx_nxt = '0;
                state_nxt  = S_WALK;
              end
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (rd_idx_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (hit || last) begin
          out_vld_nxt     = 1'b1;
          out_allowed_nxt = hit;
          out_matched_nxt = hit ? MATCH_W'(cmp_idx_r) : '0;
          out_ovf_nxt     = 1'b0;
          cmp_vld_nxt     = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filter_en_r <= 1'b0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_FILTER_ENABLE) begin
        filter_en_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    q_v6_r        <= q_v6_nxt;
    q_key_r       <= q_key_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_matched_r <= out_matched_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RULES))
    else $error("rule count exceeds table depth");

  a_filter_off_allows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.action == ACT_CHECK && !filter_en_r) |=> (out_vld_r && out_allowed_r))
    else $error("check with filtering off was not allowed");

  a_full_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.action == ACT_APPEND && fam_ok && table_full) |=>
      (out_vld_r && out_ovf_r && $stable(count_r)))
    else $error("append to full table did not flag overflow");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && cmp_vld_r) |-> (CW'(cmp_idx_r) < count_r))
    else $error("compared rule lies beyond the table fill");

endmodule

// ===== src/ipacl_rule_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix access list rule memory
// Single write port, single registered read port rule storage.
// ----------------------------------------------------------------------------
module ipacl_rule_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ipacl_pkg::rule_t wdata,
  input  logic [AW-1:0]    raddr,
  output ipacl_pkg::rule_t rdata
);
  import ipacl_pkg::*;

  rule_t mem [DEPTH];
  rule_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
